[design/lbcs_pkg.sv]
package lbcs_pkg;

  localparam int PWM_TOP_DEF     = 15;
  localparam int DIGIT_COUNT_DEF = 10;

  localparam int IN_DIGITS    = 10;
  localparam int IN_DIGITS_W  = 4 * IN_DIGITS;
  localparam int IN_TDATA_W   = 64;
  localparam int OUT_TDATA_W  = 8;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 8;

  localparam logic [3:0] DIM_LEVEL_RST       = 4'd1;
  localparam logic [3:0] BRIGHT_LEVEL_RST    = 4'd15;
  localparam logic [7:0] SHORT_BLINK_LEN_RST = 8'd25;
  localparam logic [7:0] ZERO_BLINK_LEN_RST  = 8'd10;
  localparam logic [7:0] SIGN_BLINK_LEN_RST  = 8'd100;
  localparam logic [7:0] BLINK_GAP_LEN_RST   = 8'd30;
  localparam logic [7:0] DIGIT_GAP_LEN_RST   = 8'd80;
  localparam logic [7:0] CODE_GAP_LEN_RST    = 8'd200;

  typedef enum logic [3:0] {
    PH_PAUSED   = 4'd0,
    PH_START    = 4'd1,
    PH_SIGN_ON  = 4'd2,
    PH_SIGN_OFF = 4'd3,
    PH_NEXT     = 4'd4,
    PH_ON       = 4'd5,
    PH_OFF      = 4'd6,
    PH_END      = 4'd7,
    PH_FINAL    = 4'd8,
    PH_REPEAT   = 4'd9
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIM_LEVEL       = 3'd0,
    REG_BRIGHT_LEVEL    = 3'd1,
    REG_SHORT_BLINK_LEN = 3'd2,
    REG_ZERO_BLINK_LEN  = 3'd3,
    REG_SIGN_BLINK_LEN  = 3'd4,
    REG_BLINK_GAP_LEN   = 3'd5,
    REG_DIGIT_GAP_LEN   = 3'd6,
    REG_CODE_GAP_LEN    = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

endpackage

[design/led_blink_code_sequencer.sv]
// An accepted transaction's result is registered onto out_tdata the next cycle.
// Throughput: one transaction per cycle; the phase machine and PWM counter update
//   in a single pass, and input stalls only while an unaccepted result is held.
// Reset (rst_n low, synchronous): phase paused, counters and LED cleared, config
//   registers at their defaults; the digit stores are undefined until a start.
module led_blink_code_sequencer #(
  parameter int PWM_TOP     = lbcs_pkg::PWM_TOP_DEF,
  parameter int DIGIT_COUNT = lbcs_pkg::DIGIT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // loop_count[7:0], digits[47:8], negative[48], first_digit[52:49],
  // repeat_count[60:53], zero[63:61]
  input  logic [lbcs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // op[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // led_on[0], busy_res[1], phase_now[5:2], zero[7:6]
  output logic [lbcs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbcs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lbcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PWM_W  = (PWM_TOP > 1) ? $clog2(PWM_TOP + 1) : 1;
  localparam int CMP_W  = (PWM_W > 4) ? PWM_W : 4;
  localparam int POS_W  = $clog2(DIGIT_COUNT + 1);
  localparam int IDX_W  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int DPAD_W = (4 * DIGIT_COUNT > lbcs_pkg::IN_DIGITS_W) ?
                          4 * DIGIT_COUNT : lbcs_pkg::IN_DIGITS_W;

  logic [3:0] dim_level_r, bright_level_r;
  logic [7:0] short_blink_len_r, zero_blink_len_r, sign_blink_len_r;
  logic [7:0] blink_gap_len_r, digit_gap_len_r, code_gap_len_r;

  logic [PWM_W-1:0]    pwm_count_r, pwm_count_nxt;
  lbcs_pkg::phase_t    phase_r, phase_nxt;
  logic [7:0]          phase_length_r, phase_length_nxt;
  logic [7:0]          phase_start_r, phase_start_nxt;
  logic [POS_W-1:0]    digit_pos_r, digit_pos_nxt;
  logic [7:0]          repeats_left_r, repeats_left_nxt;
  logic                sign_flag_r, sign_flag_nxt;
  logic [POS_W-1:0]    first_pos_r, first_pos_nxt;
  logic                led_r, led_nxt;
  logic [3:0]          blinks_left_r [DIGIT_COUNT];
  logic [3:0]          blinks_left_nxt [DIGIT_COUNT];
  logic [3:0]          digit_store_r [DIGIT_COUNT];
  logic [3:0]          digit_store_nxt [DIGIT_COUNT];

  logic                out_tvalid_r;
  logic [lbcs_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic                in_acc;
  logic [7:0]          now;
  logic [DPAD_W-1:0]   digits_pad;
  logic [3:0]          first_digit;
  logic                pos_valid;
  logic [3:0]          blinks_cur;
  logic [7:0]          start_eff;
  logic                pwm_at_bright;
  logic                pwm_at_dim;
  logic                done;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;

  assign now         = in_tdata[7:0];
  assign digits_pad  = DPAD_W'(in_tdata[8 +: lbcs_pkg::IN_DIGITS_W]);
  assign first_digit = in_tdata[52:49];

  assign pos_valid     = digit_pos_r < POS_W'(DIGIT_COUNT);
  assign blinks_cur    = pos_valid ? blinks_left_r[digit_pos_r[IDX_W-1:0]] : 4'd0;
  assign start_eff     = (phase_r == lbcs_pkg::PH_START && phase_start_r == 8'd0) ?
                         now : phase_start_r;
  assign pwm_at_bright = CMP_W'(pwm_count_r) == CMP_W'(bright_level_r);
  assign pwm_at_dim    = CMP_W'(pwm_count_r) == CMP_W'(dim_level_r);
  assign done          = (8'(now - start_eff) > phase_length_r) && pwm_at_bright;

  always_comb begin
    pwm_count_nxt    = pwm_count_r;
    phase_nxt        = phase_r;
    phase_length_nxt = phase_length_r;
    phase_start_nxt  = phase_start_r;
    digit_pos_nxt    = digit_pos_r;
    repeats_left_nxt = repeats_left_r;
    sign_flag_nxt    = sign_flag_r;
    first_pos_nxt    = first_pos_r;
    led_nxt          = led_r;
    blinks_left_nxt  = blinks_left_r;
    digit_store_nxt  = digit_store_r;

    if (lbcs_pkg::op_t'(in_tuser) == lbcs_pkg::OP_START) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_store_nxt[i] = (i < lbcs_pkg::IN_DIGITS) ? digits_pad[4*i +: 4] : 4'd0;
        blinks_left_nxt[i] = digit_store_nxt[i];
      end
      sign_flag_nxt = in_tdata[48];
      if ({1'b0, first_digit} > 5'(DIGIT_COUNT)) begin
        first_pos_nxt = POS_W'(DIGIT_COUNT);
      end else begin
        first_pos_nxt = POS_W'(first_digit);
      end
      digit_pos_nxt    = first_pos_nxt;
      repeats_left_nxt = in_tdata[60:53];
      phase_nxt        = lbcs_pkg::PH_START;
      phase_length_nxt = digit_gap_len_r;
      phase_start_nxt  = 8'd0;
    end else begin
      if (pwm_count_r == '0 && phase_r == lbcs_pkg::PH_PAUSED) begin
        led_nxt = 1'b0;
      end
      if (phase_r != lbcs_pkg::PH_PAUSED && pwm_count_r == '0 &&
          phase_length_r != zero_blink_len_r &&
          phase_r != lbcs_pkg::PH_REPEAT && phase_r != lbcs_pkg::PH_FINAL) begin
        led_nxt = 1'b1;
      end

      unique case (phase_r)
        lbcs_pkg::PH_START: begin
          phase_start_nxt = start_eff;
          if (pwm_at_dim) led_nxt = 1'b0;
          if (done) begin
            phase_nxt        = sign_flag_r ? lbcs_pkg::PH_SIGN_ON : lbcs_pkg::PH_NEXT;
            phase_length_nxt = sign_blink_len_r;
            phase_start_nxt  = now;
          end
        end
        lbcs_pkg::PH_SIGN_ON: begin
          if (pwm_at_bright) led_nxt = 1'b0;
          if (done) begin
            phase_nxt        = lbcs_pkg::PH_SIGN_OFF;
            phase_length_nxt = sign_blink_len_r;
            phase_start_nxt  = now;
          end
        end
        lbcs_pkg::PH_SIGN_OFF: begin
          if (pwm_at_dim) led_nxt = 1'b0;
          if (done) begin
            phase_nxt        = lbcs_pkg::PH_NEXT;
            phase_length_nxt = digit_gap_len_r;
            phase_start_nxt  = now;
          end
        end
        lbcs_pkg::PH_NEXT: begin
          phase_start_nxt = now;
          if (!pos_valid) begin
            if (repeats_left_r != 8'd0) repeats_left_nxt = repeats_left_r - 8'd1;
            phase_nxt        = lbcs_pkg::PH_END;
            phase_length_nxt = digit_gap_len_r;
          end else begin
            phase_nxt        = lbcs_pkg::PH_ON;
            phase_length_nxt = (blinks_cur == 4'd0) ? zero_blink_len_r : short_blink_len_r;
          end
        end
        lbcs_pkg::PH_ON: begin
          if (pwm_at_bright) led_nxt = 1'b0;
          if (done) begin
            led_nxt = 1'b0;
            if (blinks_cur != 4'd0) begin
              blinks_left_nxt[digit_pos_r[IDX_W-1:0]] = blinks_cur - 4'd1;
            end
            phase_nxt        = lbcs_pkg::PH_OFF;
            phase_length_nxt = (blinks_cur > 4'd1) ? blink_gap_len_r : digit_gap_len_r;
            phase_start_nxt  = now;
          end
        end
        lbcs_pkg::PH_OFF: begin
          if (pwm_at_dim) led_nxt = 1'b0;
          if (done) begin
            phase_start_nxt = now;
            if (blinks_cur != 4'd0) begin
              phase_nxt        = lbcs_pkg::PH_ON;
              phase_length_nxt = short_blink_len_r;
            end else begin
              if (pos_valid) digit_pos_nxt = digit_pos_r + POS_W'(1);
              phase_nxt = lbcs_pkg::PH_NEXT;
            end
          end
        end
        lbcs_pkg::PH_END: begin
          if (pwm_at_dim) led_nxt = 1'b0;
          if (done) begin
            phase_start_nxt = now;
            if (repeats_left_r == 8'd0) begin
              phase_nxt        = lbcs_pkg::PH_FINAL;
              phase_length_nxt = digit_gap_len_r;
            end else begin
              phase_nxt        = lbcs_pkg::PH_REPEAT;
              phase_length_nxt = code_gap_len_r;
            end
          end
        end
        lbcs_pkg::PH_FINAL: begin
          if (done) begin
            phase_nxt       = lbcs_pkg::PH_PAUSED;
            phase_start_nxt = now;
          end
        end
        lbcs_pkg::PH_REPEAT: begin
          if (done) begin
            blinks_left_nxt  = digit_store_r;
            digit_pos_nxt    = first_pos_r;
            phase_nxt        = lbcs_pkg::PH_START;
            phase_length_nxt = digit_gap_len_r;
            phase_start_nxt  = now;
          end
        end
        default: begin
        end
      endcase

      pwm_count_nxt = (pwm_count_r == PWM_W'(PWM_TOP)) ? '0 : pwm_count_r + PWM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_count_r    <= '0;
      phase_r        <= lbcs_pkg::PH_PAUSED;
      phase_length_r <= '0;
      phase_start_r  <= '0;
      digit_pos_r    <= '0;
      repeats_left_r <= '0;
      sign_flag_r    <= 1'b0;
      first_pos_r    <= '0;
      led_r          <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        pwm_count_r    <= pwm_count_nxt;
        phase_r        <= phase_nxt;
        phase_length_r <= phase_length_nxt;
        phase_start_r  <= phase_start_nxt;
        digit_pos_r    <= digit_pos_nxt;
        repeats_left_r <= repeats_left_nxt;
        sign_flag_r    <= sign_flag_nxt;
        first_pos_r    <= first_pos_nxt;
        led_r          <= led_nxt;
        out_tvalid_r   <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      blinks_left_r <= blinks_left_nxt;
      digit_store_r <= digit_store_nxt;
      out_tdata_r   <= {2'b00, phase_nxt, phase_nxt != lbcs_pkg::PH_PAUSED, led_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_level_r       <= lbcs_pkg::DIM_LEVEL_RST;
      bright_level_r    <= lbcs_pkg::BRIGHT_LEVEL_RST;
      short_blink_len_r <= lbcs_pkg::SHORT_BLINK_LEN_RST;
      zero_blink_len_r  <= lbcs_pkg::ZERO_BLINK_LEN_RST;
      sign_blink_len_r  <= lbcs_pkg::SIGN_BLINK_LEN_RST;
      blink_gap_len_r   <= lbcs_pkg::BLINK_GAP_LEN_RST;
      digit_gap_len_r   <= lbcs_pkg::DIGIT_GAP_LEN_RST;
      code_gap_len_r    <= lbcs_pkg::CODE_GAP_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lbcs_pkg::cfg_reg_t'(cfg_index))
        lbcs_pkg::REG_DIM_LEVEL:       dim_level_r       <= cfg_data[3:0];
        lbcs_pkg::REG_BRIGHT_LEVEL:    bright_level_r    <= cfg_data[3:0];
        lbcs_pkg::REG_SHORT_BLINK_LEN: short_blink_len_r <= cfg_data;
        lbcs_pkg::REG_ZERO_BLINK_LEN:  zero_blink_len_r  <= cfg_data;
        lbcs_pkg::REG_SIGN_BLINK_LEN:  sign_blink_len_r  <= cfg_data;
        lbcs_pkg::REG_BLINK_GAP_LEN:   blink_gap_len_r   <= cfg_data;
        lbcs_pkg::REG_DIGIT_GAP_LEN:   digit_gap_len_r   <= cfg_data;
        lbcs_pkg::REG_CODE_GAP_LEN:    code_gap_len_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  a_start_enters_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser |=> out_tvalid && out_tdata[5:2] == lbcs_pkg::PH_START)
    else $error("start transaction did not enter the start phase");

  a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(pwm_count_r) <= CMP_W'(PWM_TOP))
    else $error("pwm counter out of range");

  a_digit_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    digit_pos_r <= POS_W'(DIGIT_COUNT) && first_pos_r <= POS_W'(DIGIT_COUNT))
    else $error("digit position beyond digit count");

  a_busy_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1] == (out_tdata[5:2] != lbcs_pkg::PH_PAUSED))
    else $error("busy flag disagrees with phase");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import lbcs_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 30;
  localparam int NDIG        = DIGIT_COUNT_DEF;

  typedef struct packed {
    logic   led_on;
    logic   busy;
    phase_t phase_now;
  } led_state_t;

  typedef logic [7:0] cfg_vals_t [8];

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  led_blink_code_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // blink sequencer state as predicted
  logic [3:0] m_dim;
  logic [3:0] m_bright;
  logic [7:0] m_short;
  logic [7:0] m_zero;
  logic [7:0] m_sign_len;
  logic [7:0] m_bgap;
  logic [7:0] m_dgap;
  logic [7:0] m_cgap;
  logic [3:0] pwm_cnt;
  phase_t     cur_phase;
  logic [7:0] phase_len;
  logic [7:0] phase_t0;
  logic [3:0] digit_idx;
  logic [3:0] blink_cnt [NDIG];
  logic [3:0] digit_mem [NDIG];
  logic [7:0] repeats;
  logic       show_sign;
  logic [3:0] first_idx;
  logic       led_q;

  led_state_t expected_q [$];

  int   items_sent;
  int   items_seen;
  int   results_checked;
  int   error_cnt;
  int   n_ticks;
  int   n_starts;
  int   n_cfg;
  int   codes_done;
  int   cycle_cnt;
  int   rdy_left;
  bit   gaps_on;
  bit   stall_on;
  logic [7:0] loop_now;

  always #10 clk = ~clk;

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [3:0] blinks_pending(logic [3:0] pos);
    return (pos < NDIG) ? blink_cnt[pos] : 4'd0;
  endfunction

  function automatic bit phase_over(logic [7:0] now);
    return (8'(now - phase_t0) > phase_len) && (pwm_cnt == m_bright);
  endfunction

  task automatic pred_reset();
    m_dim      = DIM_LEVEL_RST;
    m_bright   = BRIGHT_LEVEL_RST;
    m_short    = SHORT_BLINK_LEN_RST;
    m_zero     = ZERO_BLINK_LEN_RST;
    m_sign_len = SIGN_BLINK_LEN_RST;
    m_bgap     = BLINK_GAP_LEN_RST;
    m_dgap     = DIGIT_GAP_LEN_RST;
    m_cgap     = CODE_GAP_LEN_RST;
    pwm_cnt    = '0;
    cur_phase  = PH_PAUSED;
    phase_len  = '0;
    phase_t0   = '0;
    digit_idx  = '0;
    repeats    = '0;
    show_sign  = 1'b0;
    first_idx  = '0;
    led_q      = 1'b0;
    for (int i = 0; i < NDIG; i++) begin
      blink_cnt[i] = '0;
      digit_mem[i] = '0;
    end
  endtask

  task automatic go_phase(phase_t nxt, logic [7:0] len, logic [7:0] now);
    cur_phase = nxt;
    phase_len = len;
    phase_t0  = now;
  endtask

  task automatic pred_tick(logic [7:0] now);
    if (pwm_cnt == 4'd0 && cur_phase == PH_PAUSED) led_q = 1'b0;
    if (cur_phase != PH_PAUSED) begin
      if (pwm_cnt == 4'd0 && phase_len != m_zero && cur_phase != PH_REPEAT &&
          cur_phase != PH_FINAL)
        led_q = 1'b1;
      case (cur_phase)
        PH_START: begin
          if (phase_t0 == 8'd0) phase_t0 = now;
          if (pwm_cnt == m_dim) led_q = 1'b0;
          if (phase_over(now)) go_phase(show_sign ? PH_SIGN_ON : PH_NEXT, m_sign_len, now);
        end
        PH_SIGN_ON: begin
          if (pwm_cnt == m_bright) led_q = 1'b0;
          if (phase_over(now)) go_phase(PH_SIGN_OFF, m_sign_len, now);
        end
        PH_SIGN_OFF: begin
          if (pwm_cnt == m_dim) led_q = 1'b0;
          if (phase_over(now)) go_phase(PH_NEXT, m_dgap, now);
        end
        PH_NEXT: begin
          if (digit_idx >= NDIG) begin
            if (repeats != 8'd0) repeats = repeats - 8'd1;
            go_phase(PH_END, m_dgap, now);
          end else begin
            go_phase(PH_ON, (blinks_pending(digit_idx) == 4'd0) ? m_zero : m_short, now);
          end
        end
        PH_ON: begin
          if (pwm_cnt == m_bright) led_q = 1'b0;
          if (phase_over(now)) begin
            led_q = 1'b0;
            if (digit_idx < NDIG && blink_cnt[digit_idx] != 4'd0)
              blink_cnt[digit_idx] = blink_cnt[digit_idx] - 4'd1;
            go_phase(PH_OFF, (blinks_pending(digit_idx) != 4'd0) ? m_bgap : m_dgap, now);
          end
        end
        PH_OFF: begin
          if (pwm_cnt == m_dim) led_q = 1'b0;
          if (phase_over(now)) begin
            if (blinks_pending(digit_idx) != 4'd0) begin
              go_phase(PH_ON, m_short, now);
            end else begin
              if (digit_idx < NDIG) digit_idx = digit_idx + 4'd1;
              cur_phase = PH_NEXT;
              phase_t0  = now;
            end
          end
        end
        PH_END: begin
          if (pwm_cnt == m_dim) led_q = 1'b0;
          if (phase_over(now)) begin
            if (repeats == 8'd0) go_phase(PH_FINAL, m_dgap, now);
            else go_phase(PH_REPEAT, m_cgap, now);
          end
        end
        PH_FINAL: begin
          if (phase_over(now)) begin
            cur_phase = PH_PAUSED;
            phase_t0  = now;
            codes_done++;
          end
        end
        PH_REPEAT: begin
          if (phase_over(now)) begin
            for (int i = 0; i < NDIG; i++) blink_cnt[i] = digit_mem[i];
            digit_idx = first_idx;
            go_phase(PH_START, m_dgap, now);
          end
        end
        default: ;
      endcase
    end
    pwm_cnt = (pwm_cnt == PWM_TOP_DEF) ? 4'd0 : pwm_cnt + 4'd1;
  endtask

  task automatic pred_start(logic [IN_TDATA_W-1:0] d);
    logic [3:0] fd;
    for (int i = 0; i < NDIG; i++) begin
      digit_mem[i] = (i < IN_DIGITS) ? d[8 + 4 * i +: 4] : 4'd0;
      blink_cnt[i] = digit_mem[i];
    end
    show_sign = d[48];
    fd        = d[52:49];
    first_idx = (fd > NDIG) ? 4'(NDIG) : fd;
    digit_idx = first_idx;
    repeats   = d[60:53];
    cur_phase = PH_START;
    phase_len = m_dgap;
    phase_t0  = 8'd0;
  endtask

  always @(posedge clk) begin : monitor
    led_state_t exp_r;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        case (cfg_index)
          REG_DIM_LEVEL:       m_dim      = cfg_data[3:0];
          REG_BRIGHT_LEVEL:    m_bright   = cfg_data[3:0];
          REG_SHORT_BLINK_LEN: m_short    = cfg_data;
          REG_ZERO_BLINK_LEN:  m_zero     = cfg_data;
          REG_SIGN_BLINK_LEN:  m_sign_len = cfg_data;
          REG_BLINK_GAP_LEN:   m_bgap     = cfg_data;
          REG_DIGIT_GAP_LEN:   m_dgap     = cfg_data;
          REG_CODE_GAP_LEN:    m_cgap     = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_START) begin
          pred_start(in_tdata);
          n_starts++;
        end else begin
          pred_tick(in_tdata[7:0]);
          n_ticks++;
        end
        expected_q.push_back(led_state_t'{led_q, cur_phase != PH_PAUSED, cur_phase});
        items_seen++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got led_on=%0b busy=%0b phase=%0d",
                     $time, out_tdata[0], out_tdata[1], out_tdata[5:2]);
        end else begin
          exp_r = expected_q.pop_front();
          results_checked++;
          if (out_tdata[0] !== exp_r.led_on || out_tdata[1] !== exp_r.busy ||
              out_tdata[5:2] !== exp_r.phase_now) begin
            error_cnt++;
            if (error_cnt <= MAX_REPORTS)
              $display("%0t: result %0d expected led_on=%0b busy=%0b phase=%0d, got %0b %0b %0d",
                       $time, results_checked, exp_r.led_on, exp_r.busy, exp_r.phase_now,
                       out_tdata[0], out_tdata[1], out_tdata[5:2]);
          end
        end
      end
    end
  end

  // receiver: bursts of ready, stalls mostly short, a few long
  always @(negedge clk) begin
    if (rdy_left > 0) begin
      rdy_left <= rdy_left - 1;
    end else if (!stall_on || $urandom_range(0, 2) != 0) begin
      out_tready <= 1'b1;
      rdy_left   <= $urandom_range(0, 15);
    end else begin
      out_tready <= 1'b0;
      rdy_left   <= pick_idle() - 1;
    end
  end

  always @(posedge clk) cycle_cnt++;

  initial begin
    wait (cycle_cnt > CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, expected_q.size());
    $display("led_blink_code_sequencer verification failed");
    $finish;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_in(logic [7:0] lc, logic [39:0] dg,
                                                    logic neg, logic [3:0] fd,
                                                    logic [7:0] rc);
    return {3'b000, rc, fd, neg, dg, lc};
  endfunction

  function automatic logic [39:0] noise40();
    return 40'({$urandom, $urandom});
  endfunction

  task automatic send_item(op_t op, logic [IN_TDATA_W-1:0] data);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_idle() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    wait (items_seen == items_sent);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, pack_in(loop_now, noise40(), 1'($urandom), 4'($urandom), 8'($urandom)));
    loop_now = loop_now + 8'd1;
  endtask

  task automatic send_start(logic [39:0] dg, logic neg, logic [3:0] fd, logic [7:0] rc);
    send_item(OP_START, pack_in(8'($urandom), dg, neg, fd, rc));
  endtask

  // tick until the code has finished or the budget runs out
  task automatic run_code(int cap);
    int n;
    n = 0;
    do begin
      send_tick();
      n++;
    end while (cur_phase != PH_PAUSED && n < cap);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(cfg_vals_t v);
    wait_idle();
    for (int i = 0; i < 8; i++) write_cfg(cfg_reg_t'(i), v[i]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_vals_t random_config();
    cfg_vals_t v;
    v[0] = 8'($urandom);
    v[1] = 8'($urandom);
    for (int i = 2; i < 8; i++)
      v[i] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    return v;
  endfunction

  function automatic logic [39:0] rand_digits();
    logic [39:0] d;
    for (int i = 0; i < IN_DIGITS; i++)
      d[4 * i +: 4] = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(0, 2))
                                                 : 4'($urandom);
    return d;
  endfunction

  function automatic logic [3:0] rand_first();
    return ($urandom_range(0, 9) < 8) ? 4'($urandom_range(7, 10)) : 4'($urandom);
  endfunction

  function automatic logic [7:0] rand_repeat();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 8'($urandom_range(1, 2));
    if (r == 8) return 8'd0;
    return 8'($urandom);
  endfunction

  task automatic test_reset_defaults();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    loop_now = 8'd0;
    send_tick();
    loop_now = 8'hFF;
    send_tick();
    send_tick();
    send_start(40'hFF_FFFF_FFFF, 1'b1, 4'hF, 8'hFF);
    repeat (12) send_tick();
    send_start(40'h0, 1'b0, 4'h0, 8'h00);
    repeat (6) send_tick();
  endtask

  task automatic test_special_cases();
    load_config('{8'd3, 8'd7, 8'd2, 8'd1, 8'd2, 8'd1, 8'd0, 8'd3});
    send_start(40'h0, 1'b0, 4'd9, 8'd1);
    run_code(1000);
    send_start({4'hC, 36'h0}, 1'b1, 4'd9, 8'd1);
    run_code(1000);
    send_start(noise40(), 1'b0, 4'd12, 8'd0);
    run_code(1000);
    send_start(noise40(), 1'b1, 4'd10, 8'd1);
    run_code(1000);
    send_start({4'h2, 4'h0, 32'h0}, 1'b1, 4'd8, 8'd1);
    repeat (30) send_tick();
    send_start({4'h1, 36'h0}, 1'b0, 4'd9, 8'd1);
    run_code(1000);
    // zero pulse length equal to blink length keeps the LED dark while on
    load_config('{8'd2, 8'd11, 8'd2, 8'd2, 8'd1, 8'd0, 8'd1, 8'd0});
    send_start({4'h3, 36'h0}, 1'b0, 4'd9, 8'd1);
    run_code(1000);
  endtask

  task automatic test_config_extremes();
    load_config('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_start({4'h3, 4'h0, 32'h0}, 1'b1, 4'd8, 8'd1);
    run_code(1000);
    load_config('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_start(noise40(), 1'b1, 4'd0, 8'hFF);
    repeat (40) send_tick();
    load_config('{8'h0F, 8'hF0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd1, 8'd1});
    send_start({4'h2, 4'h1, 32'h0}, 1'b1, 4'd8, 8'd2);
    run_code(1000);
  endtask

  task automatic test_random_codes();
    int sel;
    while (items_sent < ITEM_TARGET) begin
      gaps_on  = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 2) == 0) load_config(random_config());
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        send_start(rand_digits(), 1'($urandom), rand_first(), rand_repeat());
        run_code(400);
      end else if (sel < 9) begin
        repeat ($urandom_range(1, 20)) send_tick();
        if ($urandom_range(0, 1) == 0) loop_now = 8'($urandom);
        if ($urandom_range(0, 1) == 0)
          send_start(noise40(), 1'($urandom), 4'($urandom), 8'($urandom));
        repeat ($urandom_range(1, 40)) send_tick();
      end else begin
        // abandon a code partway; the next start cuts in
        send_start(rand_digits(), 1'($urandom), rand_first(), rand_repeat());
        repeat ($urandom_range(1, 60)) send_tick();
      end
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = 1'b0;
    out_tready      = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    items_sent      = 0;
    items_seen      = 0;
    results_checked = 0;
    error_cnt       = 0;
    n_ticks         = 0;
    n_starts        = 0;
    n_cfg           = 0;
    codes_done      = 0;
    cycle_cnt       = 0;
    rdy_left        = 0;
    gaps_on         = 1'b0;
    stall_on        = 1'b0;
    loop_now        = 8'd0;
    pred_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_special_cases();
    test_config_extremes();
    test_random_codes();
    wait_idle();

    $display("covered %0d tick and %0d start transactions, %0d register writes",
             n_ticks, n_starts, n_cfg);
    $display("%0d codes ran to the final pause, %0d results compared, %0d mismatches",
             codes_done, results_checked, error_cnt);
    if (error_cnt == 0)
      $display("led_blink_code_sequencer verification clean");
    else
      $display("led_blink_code_sequencer verification failed");
    $finish;
  end

endmodule

[files.f]
design/lbcs_pkg.sv
design/led_blink_code_sequencer.sv
tb/testbench.sv
